### rtl/assert_macros.svh
// Assertion helpers shared by the deframer RTL.
// Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Implication or plain property, checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("deframer assertion failed");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("deframer forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### rtl/pbd_pkg.sv
`timescale 1ns / 1ps

package pbd_pkg;

	localparam int ID_BYTES    = 16;
	localparam int STASH_IDX_W = $clog2(ID_BYTES);
	localparam int ID_W        = 8 * ID_BYTES;
	localparam int HDR_BYTES   = 5;
	localparam int HDR_W       = 3;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_ID_HIGH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ID_LOW    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CONT_CODE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DIR_CODE  = 2'd3;

	localparam logic [7:0] CONT_CODE_RST = 8'd0;
	localparam logic [7:0] DIR_CODE_RST  = 8'd2;

	localparam int DEFAULT_QUEUE_DEPTH = 4;

	// Action from front to back: one entry per item that yields results.
	typedef struct packed {
		logic       burst;    // replay the 16 stashed bytes
		logic       has_byte; // one data byte
		logic [7:0] data;
		logic       notice;   // switch-to-direct notice after the byte, if any
	} pbd_act_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       enter_direct;
		logic       last;
	} pbd_res_t;

endpackage

### rtl/pbd_in_if.sv
`timescale 1ns / 1ps

interface pbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_read;

	modport source (output valid, output in_byte, output end_of_read, input ready);
	modport sink (input valid, input in_byte, input end_of_read, output ready);
endinterface

### rtl/pbd_out_if.sv
`timescale 1ns / 1ps

interface pbd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       enter_direct;
	logic       last;

	modport source (output valid, output out_byte, output has_byte,
		output enter_direct, output last, input ready);
	modport sink (input valid, input out_byte, input has_byte,
		input enter_direct, input last, output ready);
endinterface

### rtl/padded_block_deframer_unit.sv
`timescale 1ns / 1ps

// Byte-stream deframer. The rx side takes one byte per cycle as long as the
// internal work queue (QUEUE_DEPTH entries) has room; a byte that yields no
// result (header, padding, identifier collection) takes no queue entry. The tx
// side gives one result per cycle while the receiver is ready: a plain byte
// gives one result, a content byte that closes a direct-command block gives the
// byte and then a notice, and the identifier mismatch replays the 16 collected
// bytes from the stash read port. Sustained rate is therefore one byte per
// cycle in every mode; rx stalls only while the tx side is backed up or a
// mismatch replay drains. Configuration writes take effect on the next edge.
module padded_block_deframer_unit import pbd_pkg::*; #(
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	pbd_in_if.sink                rx,
	pbd_out_if.source             tx,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic                   push, full, q_valid, pop;
	pbd_act_t               act, head;
	logic [STASH_IDX_W-1:0] rd_idx;
	logic [7:0]             rd_byte;

	pbd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.act       (act),
		.full      (full),
		.rd_idx    (rd_idx),
		.rd_byte   (rd_byte)
	);

	pbd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (act),
		.full   (full),
		.valid  (q_valid),
		.head   (head),
		.pop    (pop)
	);

	pbd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.head    (head),
		.pop     (pop),
		.rd_idx  (rd_idx),
		.rd_byte (rd_byte),
		.tx      (tx)
	);

endmodule

### rtl/pbd_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pbd_front import pbd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	pbd_in_if.sink                 rx,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output logic                   push,
	output pbd_act_t               act,
	input  logic                   full,
	input  logic [STASH_IDX_W-1:0] rd_idx,
	output logic [7:0]             rd_byte
);

	localparam logic [2:0] M_IDLE    = 3'd0;
	localparam logic [2:0] M_HEADER  = 3'd1;
	localparam logic [2:0] M_CONTENT = 3'd2;
	localparam logic [2:0] M_PADDING = 3'd3;
	localparam logic [2:0] M_DIRECT  = 3'd4;

	// header_left values for each header byte
	localparam logic [HDR_W-1:0] H_CMD   = HDR_W'(HDR_BYTES);
	localparam logic [HDR_W-1:0] H_CL_HI = HDR_W'(HDR_BYTES - 1);
	localparam logic [HDR_W-1:0] H_CL_LO = HDR_W'(HDR_BYTES - 2);
	localparam logic [HDR_W-1:0] H_PL_HI = HDR_W'(HDR_BYTES - 3);

	localparam logic [STASH_IDX_W-1:0] STASH_LAST = STASH_IDX_W'(ID_BYTES - 1);

	logic [63:0] id_high_q, id_low_q;
	logic [7:0]  cont_q, dir_q;

	logic [2:0]             mode_q, n_mode;
	logic [HDR_W-1:0]       hdr_q, n_hdr;
	logic [7:0]             cmd_q, n_cmd;
	logic [15:0]            cl_q, n_cl;
	logic [15:0]            pl_q, n_pl;
	logic [STASH_IDX_W-1:0] cnt_q, n_cnt;
	logic [7:0]             stash_q [ID_BYTES];

	logic       accept;
	logic       push_act;
	logic       stash_we;
	logic       end_block;
	logic [7:0] blk_cmd;
	logic [ID_W-1:0] cand;

	assign rx.ready = !full;
	assign accept   = rx.valid && !full;
	assign push     = accept && push_act;
	assign rd_byte  = stash_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_high_q <= '0;
			id_low_q  <= '0;
			cont_q    <= CONT_CODE_RST;
			dir_q     <= DIR_CODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ID_HIGH:   id_high_q <= cfg_data;
				CFG_ID_LOW:    id_low_q  <= cfg_data;
				CFG_CONT_CODE: cont_q    <= cfg_data[7:0];
				CFG_DIR_CODE:  dir_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// candidate identifier: stash plus the byte now arriving as the last one
	always_comb begin
		for (int k = 0; k < ID_BYTES; k++) begin
			if (k == ID_BYTES - 1)
				cand[ID_W-1-8*k -: 8] = rx.in_byte;
			else
				cand[ID_W-1-8*k -: 8] = stash_q[k];
		end
	end

	always_comb begin
		n_mode    = mode_q;
		n_hdr     = hdr_q;
		n_cmd     = cmd_q;
		n_cl      = cl_q;
		n_pl      = pl_q;
		n_cnt     = cnt_q;
		push_act  = 1'b0;
		act       = '0;
		stash_we  = 1'b0;
		end_block = 1'b0;
		blk_cmd   = cmd_q;
		unique case (mode_q)
			M_DIRECT: begin
				push_act     = 1'b1;
				act.has_byte = 1'b1;
				act.data     = rx.in_byte;
			end
			M_HEADER: begin
				case (hdr_q)
					H_CMD:   n_cmd = rx.in_byte;
					H_CL_HI: n_cl  = {rx.in_byte, 8'h00};
					H_CL_LO: n_cl  = {cl_q[15:8], rx.in_byte};
					H_PL_HI: n_pl  = {rx.in_byte, 8'h00};
					default: n_pl  = {pl_q[15:8], rx.in_byte};
				endcase
				if (hdr_q != '0)
					n_hdr = hdr_q - 1'b1;
				if (n_hdr == '0) begin
					blk_cmd = n_cmd;
					if (n_cl != '0)
						n_mode = M_CONTENT;
					else if (n_pl != '0)
						n_mode = M_PADDING;
					else
						end_block = 1'b1;
				end
			end
			M_CONTENT: begin
				push_act     = 1'b1;
				act.has_byte = 1'b1;
				act.data     = rx.in_byte;
				if (cl_q != '0)
					n_cl = cl_q - 1'b1;
				if (n_cl == '0) begin
					if (pl_q != '0)
						n_mode = M_PADDING;
					else
						end_block = 1'b1;
				end
			end
			M_PADDING: begin
				if (pl_q != '0)
					n_pl = pl_q - 1'b1;
				if (n_pl == '0)
					end_block = 1'b1;
			end
			default: begin
				n_mode   = M_IDLE;
				stash_we = 1'b1;
				n_cnt    = cnt_q + 1'b1;
				if (cnt_q == STASH_LAST) begin
					n_cnt = '0;
					if (cand == {id_high_q, id_low_q}) begin
						n_mode = M_HEADER;
						n_hdr  = H_CMD;
						n_cl   = '0;
						n_pl   = '0;
					end else begin
						n_mode    = M_DIRECT;
						push_act  = 1'b1;
						act.burst = 1'b1;
					end
				end
			end
		endcase

		// continue wins when both codes are equal
		if (end_block) begin
			n_cl = '0;
			n_pl = '0;
			if (blk_cmd == cont_q) begin
				n_mode = M_HEADER;
				n_hdr  = H_CMD;
			end else begin
				n_hdr = '0;
				n_cnt = '0;
				if (blk_cmd == dir_q) begin
					n_mode     = M_DIRECT;
					push_act   = 1'b1;
					act.notice = 1'b1;
				end else begin
					n_mode = M_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			hdr_q  <= '0;
			cmd_q  <= '0;
			cl_q   <= '0;
			pl_q   <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			mode_q <= n_mode;
			hdr_q  <= n_hdr;
			cmd_q  <= n_cmd;
			cl_q   <= n_cl;
			pl_q   <= n_pl;
			cnt_q  <= n_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && stash_we)
			stash_q[cnt_q] <= rx.in_byte;
	end

	`ASSERT_CLK(a_hdr_live, clk, arst_n, (mode_q == M_HEADER) |-> (hdr_q != '0))
	`ASSERT_CLK(a_content_live, clk, arst_n, (mode_q == M_CONTENT) |-> (cl_q != '0))
	`ASSERT_CLK(a_padding_live, clk, arst_n, (mode_q == M_PADDING) |-> (pl_q != '0))

endmodule

### rtl/pbd_queue.sv
`timescale 1ns / 1ps

module pbd_queue import pbd_pkg::*; #(
	parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  pbd_act_t din,
	output logic     full,
	output logic     valid,
	output pbd_act_t head,
	input  logic     pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	pbd_act_t      mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CNT_FULL);
	assign valid   = (cnt_q != '0);
	assign head    = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= din;
	end

endmodule

### rtl/pbd_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pbd_back import pbd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  pbd_act_t               head,
	output logic                   pop,
	output logic [STASH_IDX_W-1:0] rd_idx,
	input  logic [7:0]             rd_byte,
	pbd_out_if.source              tx
);

	localparam logic [STASH_IDX_W-1:0] IDX_LAST = STASH_IDX_W'(ID_BYTES - 1);

	logic                   ov_q;
	pbd_res_t               od_q;
	logic [STASH_IDX_W-1:0] idx_q, n_idx;
	logic                   ph_q, n_ph;
	logic                   load, take, fin;
	pbd_res_t               res;

	assign load   = !ov_q || tx.ready;
	assign take   = load && q_valid;
	assign pop    = take && fin;
	assign rd_idx = idx_q;

	always_comb begin
		res   = '0;
		fin   = 1'b0;
		n_idx = idx_q;
		n_ph  = ph_q;
		if (head.burst) begin
			res.out_byte     = rd_byte;
			res.has_byte     = 1'b1;
			res.enter_direct = (idx_q == '0);
			res.last         = (idx_q == IDX_LAST);
			fin              = (idx_q == IDX_LAST);
			n_idx            = fin ? '0 : idx_q + 1'b1;
		end else if (head.has_byte && !ph_q) begin
			res.out_byte = head.data;
			res.has_byte = 1'b1;
			res.last     = !head.notice;
			fin          = !head.notice;
			n_ph         = head.notice;
		end else begin
			// notice only: entering direct mode
			res.enter_direct = 1'b1;
			res.last         = 1'b1;
			fin              = 1'b1;
			n_ph             = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			idx_q <= '0;
			ph_q  <= 1'b0;
		end else begin
			if (load)
				ov_q <= q_valid;
			if (take) begin
				idx_q <= n_idx;
				ph_q  <= n_ph;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			od_q <= res;
	end

	assign tx.valid        = ov_q;
	assign tx.out_byte     = od_q.out_byte;
	assign tx.has_byte     = od_q.has_byte;
	assign tx.enter_direct = od_q.enter_direct;
	assign tx.last         = od_q.last;

	`ASSERT_CLK(a_burst_held, clk, arst_n, (idx_q != '0) |-> (q_valid && head.burst))
	`ASSERT_CLK(a_notice_held, clk, arst_n, ph_q |-> (q_valid && head.has_byte && head.notice))
	`ASSERT_CLK(a_notice_form, clk, arst_n, (ov_q && !od_q.has_byte) |-> (od_q.enter_direct && od_q.last))

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
	import pbd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int RANDOM_BYTES = 20;

	typedef enum logic [2:0] {
		DF_IDLE,
		DF_HEADER,
		DF_CONTENT,
		DF_PADDING,
		DF_DIRECT
	} deframe_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pbd_in_if rx_if ();
	pbd_out_if tx_if ();

	padded_block_deframer_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_if),
		.tx(tx_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// register shadow
	logic [63:0] id_high = '0;
	logic [63:0] id_low = '0;
	logic [7:0] cont_code = CONT_CODE_RST;
	logic [7:0] dir_code = DIR_CODE_RST;

	// deframer state mirror
	deframe_mode_t df_mode = DF_IDLE;
	logic [7:0] df_stash [ID_BYTES];
	logic [4:0] df_stash_cnt = '0;
	logic [2:0] df_hdr_left = '0;
	logic [7:0] df_cmd = '0;
	logic [15:0] df_content_left = '0;
	logic [15:0] df_padding_left = '0;

	pbd_res_t step_results[$];
	pbd_res_t deframed_q[$];

	int errors = 0;
	int unsigned cycles = 0;
	int framed_bytes = 0;
	int hold_len = 0;
	bit src_gaps = 1'b1;
	bit sink_stalls = 1'b1;

	function automatic logic [7:0] id_byte(input int k);
		if (k < 8)
			return id_high[63 - 8 * k -: 8];
		return id_low[63 - 8 * (k - 8) -: 8];
	endfunction

	function automatic void emit_result(input logic [7:0] b, input logic hb, input logic sw);
		pbd_res_t r;
		r.out_byte = b;
		r.has_byte = hb;
		r.enter_direct = sw;
		r.last = 1'b0;
		step_results.push_back(r);
	endfunction

	function automatic void back_to_idle();
		df_mode = DF_IDLE;
		df_stash_cnt = '0;
		df_hdr_left = '0;
		df_content_left = '0;
		df_padding_left = '0;
	endfunction

	function automatic void expect_header();
		df_mode = DF_HEADER;
		df_hdr_left = 3'(HDR_BYTES);
		df_content_left = '0;
		df_padding_left = '0;
	endfunction

	// continue wins when both codes are equal
	function automatic void close_block();
		if (df_cmd == cont_code) begin
			expect_header();
		end else if (df_cmd == dir_code) begin
			back_to_idle();
			df_mode = DF_DIRECT;
			emit_result(8'h00, 1'b0, 1'b1);
		end else begin
			back_to_idle();
		end
	endfunction

	function automatic void deframe_byte(input logic [7:0] b);
		logic same;
		step_results.delete();
		case (df_mode)
			DF_DIRECT: begin
				emit_result(b, 1'b1, 1'b0);
			end
			DF_HEADER: begin
				case (df_hdr_left)
					3'd5: df_cmd = b;
					3'd4: df_content_left = {b, 8'h00};
					3'd3: df_content_left = df_content_left | {8'h00, b};
					3'd2: df_padding_left = {b, 8'h00};
					default: df_padding_left = df_padding_left | {8'h00, b};
				endcase
				if (df_hdr_left != 0)
					df_hdr_left = df_hdr_left - 1'b1;
				if (df_hdr_left == 0) begin
					if (df_content_left != 0)
						df_mode = DF_CONTENT;
					else if (df_padding_left != 0)
						df_mode = DF_PADDING;
					else
						close_block();
				end
			end
			DF_CONTENT: begin
				emit_result(b, 1'b1, 1'b0);
				if (df_content_left != 0)
					df_content_left = df_content_left - 1'b1;
				if (df_content_left == 0) begin
					if (df_padding_left != 0)
						df_mode = DF_PADDING;
					else
						close_block();
				end
			end
			DF_PADDING: begin
				if (df_padding_left != 0)
					df_padding_left = df_padding_left - 1'b1;
				if (df_padding_left == 0)
					close_block();
			end
			default: begin
				df_mode = DF_IDLE;
				df_stash[df_stash_cnt[3:0]] = b;
				df_stash_cnt = df_stash_cnt + 1'b1;
				if (df_stash_cnt >= 5'(ID_BYTES)) begin
					df_stash_cnt = '0;
					same = 1'b1;
					for (int k = 0; k < ID_BYTES; k++)
						if (df_stash[k] != id_byte(k))
							same = 1'b0;
					if (same) begin
						expect_header();
					end else begin
						df_mode = DF_DIRECT;
						for (int k = 0; k < ID_BYTES; k++)
							emit_result(df_stash[k], 1'b1, k == 0);
					end
				end
			end
		endcase
		foreach (step_results[i]) begin
			pbd_res_t r;
			r = step_results[i];
			r.last = (i == step_results.size() - 1);
			deframed_q.push_back(r);
		end
	endfunction

	task automatic log_mismatch(input string msg);
		errors++;
		if (errors <= 40)
			$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			log_mismatch($sformatf("%s got %02h expected %02h", name, got, want));
	endtask

	// results are sampled at the edge and checked once the sender has updated the mirror
	always @(posedge clk) begin
		pbd_res_t got;
		pbd_res_t want;
		if (arst_n && tx_if.valid && tx_if.ready) begin
			got.out_byte = tx_if.out_byte;
			got.has_byte = tx_if.has_byte;
			got.enter_direct = tx_if.enter_direct;
			got.last = tx_if.last;
			#1;
			if (deframed_q.size() == 0) begin
				log_mismatch($sformatf("unexpected result byte %02h has_byte %0b",
					got.out_byte, got.has_byte));
			end else begin
				want = deframed_q.pop_front();
				check_field("out_byte", got.out_byte, want.out_byte);
				check_field("has_byte", got.has_byte, want.has_byte);
				check_field("enter_direct", got.enter_direct, want.enter_direct);
				check_field("last", got.last, want.last);
			end
		end
	end

	always @(posedge clk)
		cycles++;

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	// receiver: random stall bursts, plus a long hold when asked
	initial begin
		int n;
		tx_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				n = hold_len;
				hold_len = 0;
				tx_if.ready <= 1'b0;
				repeat (n) @(posedge clk);
				tx_if.ready <= 1'b1;
			end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 15);
				tx_if.ready <= 1'b0;
				repeat (n) @(posedge clk);
				tx_if.ready <= 1'b1;
			end else begin
				tx_if.ready <= 1'b1;
			end
		end
	end

	task automatic push_byte(input logic [7:0] b);
		int gap;
		if (src_gaps && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 15);
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.in_byte <= b;
		rx_if.end_of_read <= 1'($urandom_range(0, 1));
		do
			@(posedge clk);
		while (!rx_if.ready);
		deframe_byte(b);
	endtask

	// leaves the block idle with no result outstanding
	task automatic wait_idle(input int settle);
		rx_if.valid <= 1'b0;
		while (deframed_q.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_ID_HIGH: id_high = val;
			CFG_ID_LOW: id_low = val;
			CFG_CONT_CODE: cont_code = val[7:0];
			CFG_DIR_CODE: dir_code = val[7:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [63:0] hi, input logic [63:0] lo,
		input logic [7:0] cont, input logic [7:0] dir);
		cfg_write(CFG_ID_HIGH, hi);
		cfg_write(CFG_ID_LOW, lo);
		cfg_write(CFG_CONT_CODE, {56'h0, cont});
		cfg_write(CFG_DIR_CODE, {56'h0, dir});
	endtask

	function automatic logic [7:0] other_cmd();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == cont_code || c == dir_code);
		return c;
	endfunction

	task automatic send_id();
		for (int k = 0; k < ID_BYTES; k++)
			push_byte(id_byte(k));
		framed_bytes += ID_BYTES;
	endtask

	task automatic send_block(input logic [7:0] cmd, input logic [15:0] clen,
		input logic [15:0] plen);
		push_byte(cmd);
		push_byte(clen[15:8]);
		push_byte(clen[7:0]);
		push_byte(plen[15:8]);
		push_byte(plen[7:0]);
		repeat (clen) push_byte(8'($urandom_range(0, 255)));
		repeat (plen) push_byte(8'($urandom_range(0, 255)));
		framed_bytes += HDR_BYTES + clen;
	endtask

	task automatic test_reset_identifier();
		send_id();
		send_block(cont_code, 16'd2, 16'd1);
		send_block(cont_code, 16'd0, 16'd0);
		send_block(8'h55, 16'd1, 16'd0);
	endtask

	task automatic test_extreme_config();
		wait_idle(20);
		set_config('1, '1, 8'hFF, 8'h00);
		send_id();
		send_block(8'hFF, 16'd1, 16'd0);
		send_block(8'hFF, 16'd0, 16'd2);
		send_block(8'h80, 16'd0, 16'd0);
	endtask

	task automatic test_equal_codes();
		wait_idle(20);
		set_config({$urandom, $urandom}, {$urandom, $urandom}, 8'h5A, 8'h5A);
		send_id();
		send_block(8'h5A, 16'd2, 16'd0);
		send_block(8'hA5, 16'd1, 16'd1);
	endtask

	// long padding runs; padding is dropped so they cost no results
	task automatic test_long_block();
		src_gaps = 1'b0;
		send_id();
		send_block(cont_code, 16'd4, 16'd20);
		send_block(other_cmd(), 16'd0, 16'd6);
		src_gaps = 1'b1;
	endtask

	task automatic test_backpressure();
		src_gaps = 1'b0;
		send_id();
		hold_len = 200;
		send_block(cont_code, 16'd16, 16'd0);
		send_block(other_cmd(), 16'd8, 16'd0);
		src_gaps = 1'b1;
	endtask

	task automatic test_random_sessions();
		int start;
		int session;
		int blocks;
		logic [7:0] c;
		logic [15:0] clen;
		start = framed_bytes;
		session = 0;
		while (framed_bytes - start < RANDOM_BYTES) begin
			if (session % 2 == 0) begin
				wait_idle(20);
				c = 8'($urandom_range(0, 255));
				set_config({$urandom, $urandom}, {$urandom, $urandom}, c,
					($urandom_range(0, 5) == 0) ? c : 8'($urandom_range(0, 255)));
			end
			src_gaps = $urandom_range(0, 1);
			sink_stalls = $urandom_range(0, 1);
			send_id();
			blocks = $urandom_range(1, 4);
			for (int i = 0; i < blocks; i++) begin
				clen = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(20, 40))
					: 16'($urandom_range(0, 10));
				send_block((i < blocks - 1) ? cont_code : other_cmd(), clen,
					16'($urandom_range(0, 6)));
			end
			session++;
		end
		src_gaps = 1'b1;
		sink_stalls = 1'b1;
	endtask

	// leaving framed mode cannot be undone, so this runs last and picks one way in
	task automatic test_direct_entry();
		logic [7:0] c;
		logic [7:0] b;
		int bad;
		wait_idle(20);
		src_gaps = 1'b0;
		sink_stalls = 1'b0;
		c = 8'($urandom_range(0, 255));
		set_config({$urandom, $urandom}, {$urandom, $urandom}, c,
			c ^ 8'($urandom_range(1, 255)));
		case ($urandom_range(0, 3))
			0: begin
				// identifier with one flipped bit
				bad = $urandom_range(0, ID_BYTES - 1);
				for (int k = 0; k < ID_BYTES; k++) begin
					b = id_byte(k);
					if (k == bad)
						b = b ^ (8'h01 << $urandom_range(0, 7));
					push_byte(b);
				end
			end
			1: begin
				send_id();
				send_block(dir_code, 16'd0, 16'd0);
			end
			2: begin
				send_id();
				send_block(cont_code, 16'd1, 16'd1);
				send_block(dir_code, 16'd3, 16'd0);
			end
			default: begin
				send_id();
				send_block(dir_code, 16'd2, 16'd3);
			end
		endcase
		push_byte(8'h00);
		push_byte(8'hFF);
		repeat (8) push_byte(8'($urandom_range(0, 255)));
	endtask

	initial begin
		arst_n = 1'b0;
		rx_if.valid <= 1'b0;
		rx_if.in_byte <= 8'h00;
		rx_if.end_of_read <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_ID_HIGH;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_identifier();
		test_extreme_config();
		test_equal_codes();
		test_long_block();
		test_backpressure();
		test_random_sessions();
		test_direct_entry();

		wait_idle(40);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
